// ----- hdl/tpc_pkg.sv -----
// -----------------------------------------------------------------------------
// tpc_pkg
// Shared types and constants for the tablet poll controller.
// -----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

	localparam int unsigned FRAME_BYTES = 5;
	localparam int unsigned TICK_W      = 17;
	localparam int unsigned BURST_MAX   = 3;

	// Request codes carried on the input tuser
	typedef enum logic [2:0] {
		REQ_START = 3'd0,
		REQ_POLL  = 3'd1,
		REQ_BYTE  = 3'd2,
		REQ_TICK  = 3'd3,
		REQ_LERR  = 3'd4,
		REQ_STOP  = 3'd5
	} req_t;

	// Result kinds carried on the output tuser
	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_REPORT = 2'd1,
		KIND_LERR   = 2'd2
	} kind_t;

	// Tablet command bytes
	localparam logic [7:0] CMD_RESET   = 8'h20;
	localparam logic [7:0] CMD_ZERO    = 8'h00;
	localparam logic [7:0] CMD_SETUP_A = 8'h44;
	localparam logic [7:0] CMD_SETUP_B = 8'h62;
	localparam logic [7:0] CMD_SETUP_C = 8'h11;
	localparam logic [7:0] CMD_POLL    = 8'h50;
	localparam logic [7:0] CMD_STOP    = 8'h13;
	localparam logic [7:0] SYNC_MASK   = 8'h80;
	localparam logic [1:0] BTN_MASK    = 2'h3;

	// Register map (word index)
	typedef enum logic [1:0] {
		REG_PUCK     = 2'd0,
		REG_TO_BASE  = 2'd1,
		REG_TO_BYTE  = 2'd2,
		REG_SETTLE   = 2'd3
	} reg_idx_t;

	localparam logic [15:0] TO_BASE_RST = 16'd500;
	localparam logic [7:0]  TO_BYTE_RST = 8'd10;
	localparam logic [7:0]  SETTLE_RST  = 8'd15;

	typedef struct packed {
		logic        puck_mode;
		logic [15:0] timeout_base_ms;
		logic [7:0]  timeout_per_byte_ms;
		logic [7:0]  settle_ms;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tx_byte;
		logic [1:0]  buttons;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} result_t;

	typedef struct packed {
		logic [1:0]              cnt;
		result_t [BURST_MAX-1:0] res;
	} burst_t;

	function automatic result_t tx_result(input logic [7:0] b);
		result_t r;
		r         = '0;
		r.kind    = KIND_TX;
		r.tx_byte = b;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/tpc_cfg.sv -----
// -----------------------------------------------------------------------------
// tpc_cfg
// Configuration register bank on a simple APB slave port.
// -----------------------------------------------------------------------------
`default_nettype none

module tpc_cfg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [3:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output tpc_pkg::cfg_t       cfg
);
	import tpc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite & pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.puck_mode           <= 1'b0;
			cfg_q.timeout_base_ms     <= TO_BASE_RST;
			cfg_q.timeout_per_byte_ms <= TO_BYTE_RST;
			cfg_q.settle_ms           <= SETTLE_RST;
		end else if (wr) begin
			unique case (idx)
				REG_PUCK:    cfg_q.puck_mode           <= pwdata[0];
				REG_TO_BASE: cfg_q.timeout_base_ms     <= pwdata[15:0];
				REG_TO_BYTE: cfg_q.timeout_per_byte_ms <= pwdata[7:0];
				REG_SETTLE:  cfg_q.settle_ms           <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_PUCK:    prdata = {31'd0, cfg_q.puck_mode};
			REG_TO_BASE: prdata = {16'd0, cfg_q.timeout_base_ms};
			REG_TO_BYTE: prdata = {24'd0, cfg_q.timeout_per_byte_ms};
			REG_SETTLE:  prdata = {24'd0, cfg_q.settle_ms};
			default:     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/tpc_core.sv -----
// -----------------------------------------------------------------------------
// tpc_core
// Protocol state and per-event logic; builds the result burst for one event.
// -----------------------------------------------------------------------------
`default_nettype none

module tpc_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 commit,
	input  wire  [2:0]          req_type,
	input  wire  [7:0]          rx_byte,
	input  tpc_pkg::cfg_t       cfg,
	output tpc_pkg::burst_t     burst
);
	import tpc_pkg::*;

	typedef enum logic [4:0] {
		PH_CLOSED  = 5'b00001,
		PH_SETTLE1 = 5'b00010,
		PH_SETTLE2 = 5'b00100,
		PH_IDLE    = 5'b01000,
		PH_WAIT    = 5'b10000
	} phase_t;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	phase_t            phase_q, phase_d;
	logic [2:0]        nrx_q, nrx_d;
	logic [7:0]        frame_q [4];
	logic [TICK_W-1:0] tick_q, tick_d;
	logic              open_q, open_d;

	logic [TICK_W-1:0] tick_inc;
	logic [TICK_W-1:0] limit;
	logic              store_en;
	logic [1:0]        mb;
	result_t           rpt;

	assign tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;
	assign limit    = {1'b0, cfg.timeout_base_ms}
	                + TICK_W'(FRAME_BYTES) * {9'd0, cfg.timeout_per_byte_ms};

	// Position report from the four held bytes and the closing byte
	always_comb begin
		mb          = frame_q[0][1:0] & BTN_MASK;
		rpt         = '0;
		rpt.kind    = KIND_REPORT;
		rpt.buttons = cfg.puck_mode ? {mb[0], mb[1]} : mb;
		rpt.pos_x   = {8'd0, frame_q[1]} + {1'b0, frame_q[2], 7'd0};
		rpt.pos_y   = {8'd0, frame_q[3]} + {1'b0, rx_byte, 7'd0};
	end

	always_comb begin
		phase_d   = phase_q;
		nrx_d     = nrx_q;
		tick_d    = tick_q;
		open_d    = open_q;
		store_en  = 1'b0;
		burst     = '0;
		case (req_type)
			REQ_START: begin
				open_d       = 1'b1;
				burst.cnt    = 2'd2;
				burst.res[0] = tx_result(CMD_RESET);
				burst.res[1] = tx_result(CMD_ZERO);
				phase_d      = PH_SETTLE1;
				tick_d       = '0;
				nrx_d        = '0;
			end
			REQ_POLL: begin
				if (phase_q == PH_IDLE) begin
					burst.cnt    = 2'd1;
					burst.res[0] = tx_result(CMD_POLL);
					phase_d      = PH_WAIT;
					nrx_d        = '0;
					tick_d       = '0;
				end
			end
			REQ_BYTE: begin
				if (phase_q == PH_WAIT) begin
					if (nrx_q < 3'(FRAME_BYTES - 1)) begin
						store_en = 1'b1;
						nrx_d    = nrx_q + 3'd1;
					end else if ((frame_q[0] & SYNC_MASK) != 8'd0) begin
						burst.cnt    = 2'd1;
						burst.res[0] = rpt;
						phase_d      = PH_IDLE;
						nrx_d        = '0;
					end else begin
						// bad sync byte: restart setup
						burst.cnt    = 2'd2;
						burst.res[0] = tx_result(CMD_RESET);
						burst.res[1] = tx_result(CMD_ZERO);
						phase_d      = PH_SETTLE1;
						tick_d       = '0;
						nrx_d        = '0;
					end
				end
			end
			REQ_TICK: begin
				if (phase_q == PH_SETTLE1 || phase_q == PH_SETTLE2) begin
					tick_d = tick_inc;
					if (tick_inc >= {9'd0, cfg.settle_ms}) begin
						tick_d = '0;
						if (phase_q == PH_SETTLE1) begin
							burst.cnt    = 2'd3;
							burst.res[0] = tx_result(CMD_SETUP_A);
							burst.res[1] = tx_result(CMD_SETUP_B);
							burst.res[2] = tx_result(CMD_SETUP_C);
							phase_d      = PH_SETTLE2;
						end else begin
							phase_d = PH_IDLE;
						end
					end
				end else if (phase_q == PH_WAIT) begin
					tick_d = tick_inc;
					if (tick_inc > limit) begin
						burst.cnt    = 2'd2;
						burst.res[0] = tx_result(CMD_RESET);
						burst.res[1] = tx_result(CMD_ZERO);
						phase_d      = PH_SETTLE1;
						tick_d       = '0;
						nrx_d        = '0;
					end
				end
			end
			REQ_LERR: begin
				burst.cnt         = 2'd1;
				burst.res[0]      = '0;
				burst.res[0].kind = KIND_LERR;
				if (phase_q == PH_WAIT) begin
					phase_d = PH_IDLE;
					nrx_d   = '0;
					tick_d  = '0;
				end
			end
			REQ_STOP: begin
				if (open_q) begin
					burst.cnt    = 2'd1;
					burst.res[0] = tx_result(CMD_STOP);
					open_d       = 1'b0;
					phase_d      = PH_CLOSED;
					nrx_d        = '0;
					tick_d       = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CLOSED;
			nrx_q   <= '0;
			tick_q  <= '0;
			open_q  <= 1'b0;
		end else if (commit) begin
			phase_q <= phase_d;
			nrx_q   <= nrx_d;
			tick_q  <= tick_d;
			open_q  <= open_d;
		end
	end

	// Reply bytes; always written before being read
	always_ff @(posedge clk) begin
		if (commit && store_en) begin
			frame_q[nrx_q[1:0]] <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tpc_burst.sv -----
// -----------------------------------------------------------------------------
// tpc_burst
// Result register: holds the results of one event and drains one per transfer.
// -----------------------------------------------------------------------------
`default_nettype none

module tpc_burst (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  tpc_pkg::burst_t     burst,
	output logic                free,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output tpc_pkg::result_t    res,
	output logic                res_last
);
	import tpc_pkg::*;

	result_t [BURST_MAX-1:0] slot_q;
	logic [1:0]              cnt_q;
	logic [1:0]              ptr_q;
	logic                    xfer;

	assign m_tvalid = (cnt_q != 2'd0);
	assign res_last = (ptr_q == cnt_q - 2'd1);
	assign xfer     = m_tvalid & m_tready;
	assign free     = !m_tvalid || (xfer && res_last);
	assign res      = slot_q[ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (load) begin
			cnt_q <= burst.cnt;
			ptr_q <= '0;
		end else if (xfer) begin
			if (res_last) begin
				cnt_q <= '0;
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= burst.res;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tablet_poll_controller_unit.sv -----
// -----------------------------------------------------------------------------
// tablet_poll_controller_unit
// Host controller for a serial pointing tablet: setup, polling, reply framing.
// -----------------------------------------------------------------------------
// Path: an event lands in the input register at its transfer and its results
//   load into the result register once the result register is free; results then
//   leave one a cycle while m_tready is high.
// Throughput: one event per cycle while each causes at most one result and
//   m_tready is high; an event with two or three results holds the next event
//   that causes results until the result register has drained.
// Reset: arst_n clears the protocol state to closed, empties both registers
//   and loads the configuration defaults.
// -----------------------------------------------------------------------------
`default_nettype none

module tablet_poll_controller_unit (
	input  wire         clk,
	input  wire         arst_n,
	// event stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire  [2:0]  s_tuser,   // [2:0] req_type
	// result stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // [7:0] tx_byte, [9:8] buttons, [25:10] pos_x,
	                               // [41:26] pos_y, [47:42] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	// configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tpc_pkg::*;

	cfg_t    cfg;
	burst_t  burst;
	result_t res;
	logic    free;
	logic    commit;

	// Input register stage
	logic       valid_s1;
	logic [2:0] req_s1;
	logic [7:0] rx_s1;

	tpc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// An event with no results never waits on the output side; one with
	// results advances once the result register is empty or emptying.
	assign commit   = valid_s1 && (free || burst.cnt == 2'd0);
	assign s_tready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Hold the payload until the stage advances
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= s_tuser;
			rx_s1  <= s_tdata;
		end
	end

	tpc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (commit),
		.req_type (req_s1),
		.rx_byte  (rx_s1),
		.cfg      (cfg),
		.burst    (burst)
	);

	tpc_burst u_burst (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (commit && burst.cnt != 2'd0),
		.burst    (burst),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res),
		.res_last (m_tlast)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {6'd0, res.pos_y, res.pos_x, res.buttons, res.tx_byte};

endmodule

`default_nettype wire

// ----- dv/tablet_poll_controller_unit_tb.sv -----
// -----------------------------------------------------------------------------
// tablet_poll_controller_unit_tb
// Self-checking bench for the tablet poll controller: a short directed walk
// through every request and corner of the setup/poll protocol, then random
// protocol-shaped traffic under several register settings. Every result
// transfer is checked field by field against an in-bench protocol predictor or a typed expectation.
// -----------------------------------------------------------------------------
module tablet_poll_controller_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tpc_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 9;
	localparam int IDLE_PCT     = 38;
	localparam int PHASE_ITEMS  = 62;
	// Bound for the slowest expected run (about 400 events, up to three results each,
	// 38% stalls on both sides, register writes between)
	localparam int CYCLE_LIMIT  = 1_000_000;
	// Two-stage pipeline plus slack, for events that cause no result
	localparam int PIPE_FLUSH   = 6;
	localparam int NUM_PHASES   = 6;
	localparam int PREDICT      = -1;
	// Timeout runs only where the reply limit is short enough to reach
	localparam int TIMEOUT_RUN_MAX = 48;

	// Request codes with no meaning; the block must ignore them
	localparam logic [2:0]  REQ_UNUSED_LO = 3'd6;
	localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;
	localparam logic [15:0] POS_MAX       = 16'd32895;

	typedef enum logic [2:0] {
		LINK_CLOSED,
		LINK_SETTLE_A,
		LINK_SETTLE_B,
		LINK_IDLE,
		LINK_AWAIT
	} link_phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tx;
		logic [1:0]  btn;
		logic [15:0] x;
		logic [15:0] y;
		logic        last;
	} tab_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tablet_poll_controller_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------------
	// Protocol predictor: own copy of the registers and the link state
	// ---------------------------------------------------------------------
	cfg_t              link_cfg;
	link_phase_t       link_phase;
	logic [2:0]        reply_count;
	logic [7:0]        reply_bytes [4];
	logic [TICK_W-1:0] tick_cnt;
	logic              is_open;

	// Results caused by the last accepted event
	tab_result_t burst [BURST_MAX];
	int          burst_n;

	// Results still owed by the block, oldest first
	tab_result_t due_results [$];

	// Directed stimulus rows; dir_n is PREDICT or the count of typed results
	logic [2:0]  dir_req [$];
	logic [7:0]  dir_rx [$];
	int          dir_n [$];
	tab_result_t dir_res [$];

	int errors = 0;
	int cycles = 0;
	bit no_idle = 1'b0;

	function automatic void clear_link();
		link_cfg.puck_mode           = 1'b0;
		link_cfg.timeout_base_ms     = TO_BASE_RST;
		link_cfg.timeout_per_byte_ms = TO_BYTE_RST;
		link_cfg.settle_ms           = SETTLE_RST;
		link_phase  = LINK_CLOSED;
		reply_count = '0;
		tick_cnt    = '0;
		is_open     = 1'b0;
		for (int i = 0; i < 4; i++)
			reply_bytes[i] = '0;
	endfunction

	function automatic void emit_result(kind_t k, logic [7:0] tx, logic [1:0] b,
	                                    logic [15:0] x, logic [15:0] y);
		burst[burst_n].kind = k;
		burst[burst_n].tx   = tx;
		burst[burst_n].btn  = b;
		burst[burst_n].x    = x;
		burst[burst_n].y    = y;
		burst[burst_n].last = 1'b0;
		burst_n++;
	endfunction

	// Send the first setup burst and start settling
	function automatic void restart_setup();
		emit_result(KIND_TX, CMD_RESET, '0, '0, '0);
		emit_result(KIND_TX, CMD_ZERO, '0, '0, '0);
		link_phase  = LINK_SETTLE_A;
		tick_cnt    = '0;
		reply_count = '0;
	endfunction

	// Tick counter holds at its maximum
	function automatic void bump_ticks();
		if (tick_cnt != '1)
			tick_cnt = tick_cnt + 1'b1;
	endfunction

	function automatic int reply_limit();
		return int'(link_cfg.timeout_base_ms) + FRAME_BYTES * int'(link_cfg.timeout_per_byte_ms);
	endfunction

	function automatic void apply_event(logic [2:0] req, logic [7:0] rx);
		logic [1:0]  btn;
		logic [15:0] px;
		logic [15:0] py;
		burst_n = 0;
		case (req)
			REQ_START: begin
				is_open = 1'b1;
				restart_setup();
			end
			REQ_POLL: begin
				if (link_phase == LINK_IDLE) begin
					emit_result(KIND_TX, CMD_POLL, '0, '0, '0);
					link_phase  = LINK_AWAIT;
					reply_count = '0;
					tick_cnt    = '0;
				end
			end
			REQ_BYTE: begin
				// Outside a reply the byte is flushed
				if (link_phase == LINK_AWAIT) begin
					if (reply_count < FRAME_BYTES - 1) begin
						reply_bytes[reply_count[1:0]] = rx;
						reply_count = reply_count + 1'b1;
					end else if ((reply_bytes[0] & SYNC_MASK) != '0) begin
						btn = reply_bytes[0][1:0] & BTN_MASK;
						if (link_cfg.puck_mode)
							btn = {btn[0], btn[1]};
						px = 16'(reply_bytes[1]) + (16'(reply_bytes[2]) << 7);
						py = 16'(reply_bytes[3]) + (16'(rx) << 7);
						emit_result(KIND_REPORT, 8'h00, btn, px, py);
						link_phase  = LINK_IDLE;
						reply_count = '0;
					end else begin
						// Lost sync: start over
						restart_setup();
					end
				end
			end
			REQ_TICK: begin
				if (link_phase == LINK_SETTLE_A || link_phase == LINK_SETTLE_B) begin
					bump_ticks();
					if (tick_cnt >= TICK_W'(link_cfg.settle_ms)) begin
						tick_cnt = '0;
						if (link_phase == LINK_SETTLE_A) begin
							emit_result(KIND_TX, CMD_SETUP_A, '0, '0, '0);
							emit_result(KIND_TX, CMD_SETUP_B, '0, '0, '0);
							emit_result(KIND_TX, CMD_SETUP_C, '0, '0, '0);
							link_phase = LINK_SETTLE_B;
						end else begin
							link_phase = LINK_IDLE;
						end
					end
				end else if (link_phase == LINK_AWAIT) begin
					bump_ticks();
					if (int'(tick_cnt) > reply_limit())
						restart_setup();
				end
			end
			REQ_LERR: begin
				emit_result(KIND_LERR, 8'h00, '0, '0, '0);
				if (link_phase == LINK_AWAIT) begin
					link_phase  = LINK_IDLE;
					reply_count = '0;
					tick_cnt    = '0;
				end
			end
			REQ_STOP: begin
				if (is_open) begin
					emit_result(KIND_TX, CMD_STOP, '0, '0, '0);
					is_open     = 1'b0;
					link_phase  = LINK_CLOSED;
					reply_count = '0;
					tick_cnt    = '0;
				end
			end
			default: ;
		endcase
		if (burst_n > 0)
			burst[burst_n - 1].last = 1'b1;
	endfunction

	function automatic void queue_burst();
		for (int k = 0; k < burst_n; k++)
			due_results.push_back(burst[k]);
	endfunction

	// ---------------------------------------------------------------------
	// Directed rows
	// ---------------------------------------------------------------------
	function automatic void row(logic [2:0] req, logic [7:0] rx, int n);
		dir_req.push_back(req);
		dir_rx.push_back(rx);
		dir_n.push_back(n);
	endfunction

	function automatic void want(kind_t k, logic [7:0] tx, logic [1:0] b,
	                             logic [15:0] x, logic [15:0] y, logic last);
		tab_result_t r;
		r.kind = k;
		r.tx   = tx;
		r.btn  = b;
		r.x    = x;
		r.y    = y;
		r.last = last;
		dir_res.push_back(r);
	endfunction

	// Runs with puck mode on, both timeouts zero and settle zero
	function automatic void build_directed();
		// Nothing open yet: only the line error answers
		row(REQ_STOP, 8'h00, 0);
		row(REQ_POLL, 8'h00, 0);
		row(REQ_BYTE, 8'hA5, 0);
		row(REQ_TICK, 8'h00, 0);
		row(REQ_LERR, 8'h00, 1);
		want(KIND_LERR, 8'h00, 2'b00, 16'h0000, 16'h0000, 1'b1);
		row(REQ_UNUSED_LO, 8'hFF, 0);
		row(REQ_UNUSED_HI, 8'h00, 0);
		row(REQ_START, 8'h00, 2);
		want(KIND_TX, CMD_RESET, 2'b00, 16'h0000, 16'h0000, 1'b0);
		want(KIND_TX, CMD_ZERO, 2'b00, 16'h0000, 16'h0000, 1'b1);
		// Settle zero: the first tick ends each settle phase
		row(REQ_TICK, 8'h00, PREDICT);
		row(REQ_BYTE, 8'h5A, PREDICT);
		row(REQ_TICK, 8'h00, PREDICT);
		row(REQ_POLL, 8'h00, PREDICT);
		row(REQ_POLL, 8'h00, PREDICT);
		// Full-scale report; puck mode swaps button bits 01 to 10
		row(REQ_BYTE, 8'h81, PREDICT);
		row(REQ_BYTE, 8'hFF, PREDICT);
		row(REQ_BYTE, 8'hFF, PREDICT);
		row(REQ_BYTE, 8'hFF, PREDICT);
		row(REQ_BYTE, 8'hFF, 1);
		want(KIND_REPORT, 8'h00, 2'b10, POS_MAX, POS_MAX, 1'b1);
		// Zero reply limit: the first tick times out
		row(REQ_POLL, 8'h00, PREDICT);
		row(REQ_TICK, 8'h00, PREDICT);
		// Start while open goes back to the first burst
		row(REQ_START, 8'h00, PREDICT);
		row(REQ_TICK, 8'h00, PREDICT);
		row(REQ_TICK, 8'h00, PREDICT);
		// Line error while awaiting drops the reply
		row(REQ_POLL, 8'h00, PREDICT);
		row(REQ_LERR, 8'h00, PREDICT);
		row(REQ_STOP, 8'h00, 1);
		want(KIND_TX, CMD_STOP, 2'b00, 16'h0000, 16'h0000, 1'b1);
		row(REQ_STOP, 8'h00, 0);
	endfunction

	// ---------------------------------------------------------------------
	// Bus drivers (called at a rising edge, drive with nonblocking writes)
	// ---------------------------------------------------------------------
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		// Drop select for a cycle so the next write sees a fresh setup phase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PUCK:    link_cfg.puck_mode           = val[0];
			REG_TO_BASE: link_cfg.timeout_base_ms     = val[15:0];
			REG_TO_BYTE: link_cfg.timeout_per_byte_ms = val[7:0];
			REG_SETTLE:  link_cfg.settle_ms           = val[7:0];
			default: ;
		endcase
	endtask

	task automatic program_cfg(input logic puck, input logic [15:0] base,
	                           input logic [7:0] per_byte, input logic [7:0] settle);
		write_reg(REG_PUCK, 32'(puck));
		write_reg(REG_TO_BASE, 32'(base));
		write_reg(REG_TO_BYTE, 32'(per_byte));
		write_reg(REG_SETTLE, 32'(settle));
	endtask

	// Present one event, hold it until the transfer, then advance the predictor
	task automatic feed(input logic [2:0] req, input logic [7:0] rx);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= rx;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_event(req, rx);
	endtask

	// Hold the input low until every owed result is back, then let the
	// pipeline empty out events that caused none
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_FLUSH) @(posedge clk);
	endtask

	// Mostly what the protocol wants next, with some noise mixed in
	task automatic pick_event(output logic [2:0] req, output logic [7:0] rx);
		int p;
		p   = $urandom_range(0, 99);
		rx  = 8'($urandom_range(0, 255));
		req = 3'($urandom_range(0, 7));
		case (link_phase)
			LINK_CLOSED: if (p < 85) req = REQ_START;
			LINK_SETTLE_A, LINK_SETTLE_B: if (p < 85) req = REQ_TICK;
			LINK_IDLE: if (p < 80) req = REQ_POLL;
			LINK_AWAIT: begin
				if (p < 82) begin
					req = REQ_BYTE;
					// Keep most frames in sync
					if (reply_count == 0 && $urandom_range(0, 99) < 85)
						rx[7] = 1'b1;
				end else if (p < 90) begin
					req = REQ_TICK;
				end
			end
			default: ;
		endcase
	endtask

	task automatic run_phase();
		int         done;
		logic [2:0] req;
		logic [7:0] rx;
		done = 0;
		while (done < PHASE_ITEMS) begin
			if (link_phase == LINK_AWAIT && reply_limit() < TIMEOUT_RUN_MAX &&
			    $urandom_range(0, 99) < 4) begin
				// Tick until the reply times out
				while (link_phase == LINK_AWAIT) begin
					feed(REQ_TICK, 8'($urandom_range(0, 255)));
					queue_burst();
					done++;
				end
			end else begin
				pick_event(req, rx);
				feed(req, rx);
				queue_burst();
				done++;
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Result checker and sink-side stalls
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		tab_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: expected no result, got kind %0d tdata %h last %b",
				         $time, m_tuser, m_tdata, m_tlast);
			end else begin
				exp_r = due_results.pop_front();
				if (m_tuser !== exp_r.kind || m_tdata[7:0] !== exp_r.tx ||
				    m_tdata[9:8] !== exp_r.btn || m_tdata[25:10] !== exp_r.x ||
				    m_tdata[41:26] !== exp_r.y || m_tdata[47:42] !== 6'd0 ||
				    m_tlast !== exp_r.last) begin
					errors++;
					$display("%0t: expected kind %0d tx %h btn %b x %0d y %0d pad 0 last %b, got kind %0d tx %h btn %b x %0d y %0d pad %h last %b",
					         $time, exp_r.kind, exp_r.tx, exp_r.btn, exp_r.x, exp_r.y,
					         exp_r.last, m_tuser, m_tdata[7:0], m_tdata[9:8],
					         m_tdata[25:10], m_tdata[41:26], m_tdata[47:42], m_tlast);
				end
			end
		end
		m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Sequence: reset, directed rows, random phases, drain
	// ---------------------------------------------------------------------
	initial begin
		int res_idx;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		clear_link();
		build_directed();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_cfg(1'b1, 16'd0, 8'd0, 8'd0);
		res_idx = 0;
		for (int i = 0; i < dir_req.size(); i++) begin
			feed(dir_req[i], dir_rx[i]);
			if (dir_n[i] == PREDICT) begin
				queue_burst();
			end else begin
				for (int k = 0; k < dir_n[i]; k++) begin
					due_results.push_back(dir_res[res_idx]);
					res_idx++;
				end
			end
		end
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: program_cfg(1'b0, TO_BASE_RST, TO_BYTE_RST, SETTLE_RST);
				1: program_cfg(1'b1, 16'd0, 8'd0, 8'd0);
				2: program_cfg(1'b0, 16'hFFFF, 8'hFF, 8'hFF);
				3: program_cfg(1'b1, 16'($urandom_range(0, 40)),
				               8'($urandom_range(0, 8)), 8'($urandom_range(0, 6)));
				4: program_cfg(1'($urandom_range(0, 1)), 16'($urandom_range(0, 300)),
				               8'($urandom_range(0, 20)), 8'($urandom_range(0, 10)));
				default: program_cfg(1'b1, 16'd200, 8'd3, 8'd1);
			endcase
			// One whole phase runs with no stalls on either side
			no_idle = (p == 4);
			run_phase();
			drain_results();
		end
		no_idle = 1'b0;

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/tpc_pkg.sv
hdl/tpc_cfg.sv
hdl/tpc_core.sv
hdl/tpc_burst.sv
hdl/tablet_poll_controller_unit.sv
dv/tablet_poll_controller_unit_tb.sv
